@@ rtl/psf_pkg.sv @@
// psf_pkg: shared types and constants of the pedestal subtracting fir filter
// used by psf_cell and pedestal_subtract_fir_filter; no dependencies

package psf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LIMIT_W    = 10;
    localparam int INIT_PED_W = 14;
    localparam int SHIFT_W    = 4;
    localparam int COUNT_W    = 12;
    localparam int TAP_W      = 8;
    localparam int OUT_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONTIG_LIMIT     = 2'd0,
        REG_INITIAL_PEDESTAL = 2'd1,
        REG_TAP_WORDS        = 2'd2,
        REG_OUTPUT_SHIFT     = 2'd3
    } cfg_reg_t;

    localparam logic [LIMIT_W-1:0]    CONTIG_LIMIT_RST = 10'd10;
    localparam logic [INIT_PED_W-1:0] INIT_PED_RST     = 14'd1000;
    localparam logic [CFG_DATA_W-1:0] TAP_WORDS_RST    = 64'd572944863922434;
    localparam logic [SHIFT_W-1:0]    OUT_SHIFT_RST    = 4'd6;

    // per cell control, broadcast along the chain
    typedef struct packed {
        logic load;
        logic start;
    } cell_ctrl_t;

endpackage

@@ rtl/psf_cell.sv @@
// psf_cell: one fir cell, holds one history sample and its tap product
// depends on psf_pkg

module psf_cell #(
    parameter int DATA_W = 15
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  psf_pkg::cell_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0]           x_in,
    input  logic signed [DATA_W-1:0]           hist_in,
    input  logic signed [psf_pkg::TAP_W-1:0]   tap,
    output logic signed [DATA_W-1:0]           hist_out,
    output logic signed [DATA_W+psf_pkg::TAP_W-1:0] prod_out
);

    localparam int PROD_W = DATA_W + psf_pkg::TAP_W;

    logic signed [DATA_W-1:0] hist_reg;
    logic signed [DATA_W-1:0] hist_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // waveform start fills the whole history with the current word
    assign hist_next = ctrl.start ? x_in : hist_in;
    assign prod_next = PROD_W'(hist_next) * PROD_W'(tap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (ctrl.load) begin
            hist_reg <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            prod_reg <= prod_next;
        end
    end

    assign hist_out = hist_reg;
    assign prod_out = prod_reg;

endmodule

@@ rtl/pedestal_subtract_fir_filter.sv @@
// pedestal_subtract_fir_filter: pipelined from input word to result word
// throughput one word per cycle while m_ready does not hold the output: median update, cell
// products, tap sum, shift each take one pipeline stage; the fir is a chain of NTAPS cells
// synchronous active low reset: config registers to defaults, median 1000,
// step counter and history zero, pipeline empty
// depends on psf_pkg and psf_cell

module pedestal_subtract_fir_filter #(
    parameter int NTAPS       = 7,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_wr_en,
    input  logic [psf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [psf_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [SAMPLE_BITS-1:0]                s_adc_sample,
    input  logic                                  s_waveform_start,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [SAMPLE_BITS-1:0]                m_pedestal,
    output logic signed [SAMPLE_BITS:0]           m_pedestal_subtracted,
    output logic signed [psf_pkg::OUT_W-1:0]      m_filtered
);

    localparam int DATA_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DATA_W + psf_pkg::TAP_W;
    localparam int SUM_W  = PROD_W + $clog2(NTAPS);
    localparam int CNT_W  = psf_pkg::COUNT_W;
    localparam logic [SAMPLE_BITS-1:0] MEDIAN_RST = SAMPLE_BITS'(psf_pkg::INIT_PED_RST);
    localparam logic [SAMPLE_BITS-1:0] MEDIAN_MAX = '1;

    // configuration
    logic [psf_pkg::LIMIT_W-1:0]    contig_limit_reg;
    logic [psf_pkg::INIT_PED_W-1:0] init_ped_reg;
    logic [psf_pkg::CFG_DATA_W-1:0] tap_words_reg;
    logic [psf_pkg::SHIFT_W-1:0]    out_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contig_limit_reg <= psf_pkg::CONTIG_LIMIT_RST;
            init_ped_reg     <= psf_pkg::INIT_PED_RST;
            tap_words_reg    <= psf_pkg::TAP_WORDS_RST;
            out_shift_reg    <= psf_pkg::OUT_SHIFT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psf_pkg::REG_CONTIG_LIMIT: begin
                    contig_limit_reg <= cfg_wdata[psf_pkg::LIMIT_W-1:0];
                end
                psf_pkg::REG_INITIAL_PEDESTAL: begin
                    init_ped_reg <= cfg_wdata[psf_pkg::INIT_PED_W-1:0];
                end
                psf_pkg::REG_TAP_WORDS: begin
                    tap_words_reg <= cfg_wdata;
                end
                psf_pkg::REG_OUTPUT_SHIFT: begin
                    out_shift_reg <= cfg_wdata[psf_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !m_valid || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                m_valid <= v3_reg;
            end
        end
    end

    // stage 1: frugal median and pedestal subtraction
    logic [SAMPLE_BITS-1:0]     median_reg, median_next, median_base;
    logic signed [CNT_W-1:0]    count_reg, count_next, count_base, count_step;
    logic signed [CNT_W-1:0]    lim_pos, lim_neg;
    logic signed [DATA_W-1:0]   pedsub_next;
    logic [SAMPLE_BITS-1:0]     ped1_reg;
    logic signed [DATA_W-1:0]   pedsub1_reg;
    logic                       start1_reg;
    logic                       load1;

    assign load1   = s_valid && rdy1;
    assign lim_pos = $signed(CNT_W'(contig_limit_reg));
    assign lim_neg = -lim_pos;

    always_comb begin
        median_base = s_waveform_start ? SAMPLE_BITS'(init_ped_reg) : median_reg;
        count_base  = s_waveform_start ? '0 : count_reg;
        count_step  = count_base;
        if (s_adc_sample > median_base) begin
            count_step = count_base + CNT_W'(1);
        end else if (s_adc_sample < median_base) begin
            count_step = count_base - CNT_W'(1);
        end
        median_next = median_base;
        count_next  = count_step;
        priority if (count_step > lim_pos) begin
            if (median_base != MEDIAN_MAX) begin
                median_next = median_base + SAMPLE_BITS'(1);
            end
            count_next = '0;
        end else if (count_step < lim_neg) begin
            if (median_base != '0) begin
                median_next = median_base - SAMPLE_BITS'(1);
            end
            count_next = '0;
        end
        pedsub_next = $signed({1'b0, s_adc_sample}) - $signed({1'b0, median_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            median_reg <= MEDIAN_RST;
            count_reg  <= '0;
        end else if (load1) begin
            median_reg <= median_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            ped1_reg    <= median_next;
            pedsub1_reg <= pedsub_next;
            start1_reg  <= s_waveform_start;
        end
    end

    // stage 2: chain of fir cells
    psf_pkg::cell_ctrl_t      cell_ctrl;
    logic signed [DATA_W-1:0] hist [NTAPS];
    logic signed [PROD_W-1:0] prod [NTAPS];
    logic [SAMPLE_BITS-1:0]   ped2_reg;
    logic signed [DATA_W-1:0] pedsub2_reg;

    assign cell_ctrl.load  = v1_reg && rdy2;
    assign cell_ctrl.start = start1_reg;
    assign hist[0]         = pedsub1_reg;

    for (genvar j = 0; j < NTAPS; j++) begin : g_cell
        if (j < NTAPS - 1) begin : g_mid
            psf_cell #(
                .DATA_W (DATA_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .x_in     (pedsub1_reg),
                .hist_in  (hist[j]),
                .tap      ($signed(tap_words_reg[psf_pkg::TAP_W*j +: psf_pkg::TAP_W])),
                .hist_out (hist[j+1]),
                .prod_out (prod[j])
            );
        end else begin : g_last
            psf_cell #(
                .DATA_W (DATA_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .x_in     (pedsub1_reg),
                .hist_in  (hist[j]),
                .tap      ($signed(tap_words_reg[psf_pkg::TAP_W*j +: psf_pkg::TAP_W])),
                .hist_out (),
                .prod_out (prod[j])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_ctrl.load) begin
            ped2_reg    <= ped1_reg;
            pedsub2_reg <= pedsub1_reg;
        end
    end

    // stage 3: tap sum
    logic signed [SUM_W-1:0]  sum_next, sum3_reg;
    logic [SAMPLE_BITS-1:0]   ped3_reg;
    logic signed [DATA_W-1:0] pedsub3_reg;

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < NTAPS; j++) begin
            sum_next = sum_next + SUM_W'(prod[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            sum3_reg    <= sum_next;
            ped3_reg    <= ped2_reg;
            pedsub3_reg <= pedsub2_reg;
        end
    end

    // stage 4: shift and wrap into the output word
    logic signed [SUM_W-1:0] shifted;

    assign shifted = sum3_reg >>> out_shift_reg;

    always_ff @(posedge aclk) begin
        if (v3_reg && rdy4) begin
            m_pedestal            <= ped3_reg;
            m_pedestal_subtracted <= pedsub3_reg;
            m_filtered            <= shifted[psf_pkg::OUT_W-1:0];
        end
    end

endmodule

@@ test/psf_checker.sv @@
// psf_checker: watches the config port and both word channels of the pedestal
// subtracting fir filter, predicts every result word and compares it field by field
// depends on psf_pkg
`timescale 1ns / 1ps

module psf_checker #(
    parameter int NTAPS       = 7,
    parameter int SAMPLE_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [psf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [psf_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  logic [SAMPLE_BITS-1:0]                s_adc_sample,
    input  logic                                  s_waveform_start,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  logic [SAMPLE_BITS-1:0]                m_pedestal,
    input  logic signed [SAMPLE_BITS:0]           m_pedestal_subtracted,
    input  logic signed [psf_pkg::OUT_W-1:0]      m_filtered,
    output int                                    fail_count,
    output int                                    pending_words
);
    import psf_pkg::*;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]  ped;
        logic signed [SAMPLE_BITS:0] diff;
        logic signed [OUT_W-1:0] filt;
    } ped_word_t;

    ped_word_t expected_words[$];

    logic [LIMIT_W-1:0]    contig_limit;
    logic [INIT_PED_W-1:0] initial_pedestal;
    logic [CFG_DATA_W-1:0] tap_words;
    logic [SHIFT_W-1:0]    output_shift;

    logic [SAMPLE_BITS-1:0] median;
    int                     step_count;
    int                     diff_history[NTAPS];

    function automatic int tap_coef(input int j);
        return int'($signed(tap_words[8*j +: 8]));
    endfunction

    function automatic ped_word_t subtract_and_filter(input logic [SAMPLE_BITS-1:0] smp,
                                                      input logic start);
        ped_word_t r;
        int        diff;
        longint    acc;
        int        j;
        if (start) begin
            median     = initial_pedestal[SAMPLE_BITS-1:0];
            step_count = 0;
        end
        if (smp > median) step_count++;
        if (smp < median) step_count--;
        if (step_count > int'(contig_limit)) begin
            if (median != SAMPLE_MAX) median++;
            step_count = 0;
        end
        if (step_count < -int'(contig_limit)) begin
            if (median != '0) median--;
            step_count = 0;
        end
        diff = int'(smp) - int'(median);
        if (start) begin
            for (j = 0; j < NTAPS; j++) diff_history[j] = diff;
        end
        acc = longint'(diff) * tap_coef(0);
        for (j = 1; j < NTAPS; j++) acc += longint'(diff_history[j-1]) * tap_coef(j);
        acc = acc >>> output_shift;
        for (j = NTAPS - 1; j > 0; j--) diff_history[j] = diff_history[j-1];
        diff_history[0] = diff;
        r.ped  = median;
        r.diff = diff[SAMPLE_BITS:0];
        r.filt = acc[OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        ped_word_t want;
        if (!aresetn) begin
            fail_count       = 0;
            contig_limit     = CONTIG_LIMIT_RST;
            initial_pedestal = INIT_PED_RST;
            tap_words        = TAP_WORDS_RST;
            output_shift     = OUT_SHIFT_RST;
            median           = INIT_PED_RST[SAMPLE_BITS-1:0];
            step_count       = 0;
            for (int j = 0; j < NTAPS; j++) diff_history[j] = 0;
            expected_words.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CONTIG_LIMIT:     contig_limit     = cfg_wdata[LIMIT_W-1:0];
                    REG_INITIAL_PEDESTAL: initial_pedestal = cfg_wdata[INIT_PED_W-1:0];
                    REG_TAP_WORDS:        tap_words        = cfg_wdata;
                    REG_OUTPUT_SHIFT:     output_shift     = cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_words.insert(expected_words.size(),
                                      subtract_and_filter(s_adc_sample, s_waveform_start));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with none expected: ped %0d diff %0d filt %0d",
                             $time, m_pedestal, m_pedestal_subtracted, m_filtered);
                end else begin
                    want = expected_words.pop_front();
                    check_field("pedestal", int'(want.ped), int'(m_pedestal));
                    check_field("pedestal_subtracted", int'($signed(want.diff)),
                                int'(m_pedestal_subtracted));
                    check_field("filtered", int'($signed(want.filt)), int'(m_filtered));
                end
            end
        end
        pending_words <= expected_words.size();
    end

endmodule

@@ test/tb.sv @@
// tb: top of the pedestal subtracting fir filter testbench; drives directed and
// waveform-shaped random sample words with random idling, checking done by psf_checker
// depends on psf_pkg, psf_checker and pedestal_subtract_fir_filter
`timescale 1ns / 1ps

module tb;
    import psf_pkg::*;

    localparam int NTAPS       = 7;
    localparam int SAMPLE_BITS = 14;
    localparam int ADC_TOP     = (1 << SAMPLE_BITS) - 1;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_wdata;
    logic                          s_valid;
    wire                           s_ready;
    logic [SAMPLE_BITS-1:0]        s_adc_sample;
    logic                          s_waveform_start;
    wire                           m_valid;
    logic                          m_ready;
    wire [SAMPLE_BITS-1:0]         m_pedestal;
    wire signed [SAMPLE_BITS:0]    m_pedestal_subtracted;
    wire signed [OUT_W-1:0]        m_filtered;

    int   fail_count;
    int   pending_words;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   words_sent;
    logic stall_req;

    pedestal_subtract_fir_filter #(
        .NTAPS(NTAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_adc_sample(s_adc_sample),
        .s_waveform_start(s_waveform_start),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pedestal(m_pedestal),
        .m_pedestal_subtracted(m_pedestal_subtracted),
        .m_filtered(m_filtered)
    );

    psf_checker #(
        .NTAPS(NTAPS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_adc_sample(s_adc_sample),
        .s_waveform_start(s_waveform_start),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_pedestal(m_pedestal),
        .m_pedestal_subtracted(m_pedestal_subtracted),
        .m_filtered(m_filtered),
        .fail_count(fail_count),
        .pending_words(pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        int   hold;
        logic stall_taken;
        hold        = 0;
        stall_taken = 1'b0;
        m_ready     = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_req && !stall_taken) begin
                stall_taken = 1'b1;
                hold        = 300;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= aresetn && (int'($urandom_range(99, 0)) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v < 0) return '0;
        if (v > ADC_TOP) return ADC_TOP[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic send_word(input logic [SAMPLE_BITS-1:0] smp, input logic start);
        while (int'($urandom_range(99, 0)) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_adc_sample     <= smp;
        s_waveform_start <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_waveform(input int base);
        int len;
        int v;
        int k;
        len = int'($urandom_range(60, 4));
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99, 0) < 8)
                v = base + int'($urandom_range(6000, 0)) - 3000;
            else
                v = base + int'($urandom_range(8, 0)) - 4;
            send_word(clamp_sample(v), k == 0);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [LIMIT_W-1:0] lim, input logic [INIT_PED_W-1:0] ped,
                                input logic [CFG_DATA_W-1:0] taps,
                                input logic [SHIFT_W-1:0] sh);
        write_reg(REG_CONTIG_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_INITIAL_PEDESTAL, CFG_DATA_W'(ped));
        write_reg(REG_TAP_WORDS, taps);
        write_reg(REG_OUTPUT_SHIFT, CFG_DATA_W'(sh));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int phase;
        int phase_base;
        int base;
        int k;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = REG_CONTIG_LIMIT;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_adc_sample     = '0;
        s_waveform_start = 1'b0;
        stall_req        = 1'b0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        words_sent       = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config, history still zero before the first start
        send_word(ADC_TOP, 1'b0);
        send_word('0, 1'b0);
        send_word(14'd1000, 1'b0);
        send_word(ADC_TOP, 1'b1);
        send_word(ADC_TOP, 1'b0);
        send_word(ADC_TOP, 1'b0);
        send_word('0, 1'b0);
        send_word('0, 1'b0);
        wait_idle();

        // limit zero, top pedestal, most negative taps, no shift: wraps the sum
        apply_config('0, '1, 64'h8080_8080_8080_8080, '0);
        send_word('0, 1'b1);
        send_word(ADC_TOP, 1'b0);
        send_word('0, 1'b0);
        send_word(ADC_TOP, 1'b0);
        send_word(14'd8191, 1'b0);
        send_word(14'd8192, 1'b0);
        send_word('0, 1'b1);
        send_word(ADC_TOP, 1'b0);
        wait_idle();

        // top limit, zero pedestal, most positive taps, top shift
        apply_config('1, '0, 64'h7F7F_7F7F_7F7F_7F7F, '1);
        send_word(ADC_TOP, 1'b1);
        send_word(ADC_TOP, 1'b0);
        send_word('0, 1'b0);
        send_word(14'd1, 1'b0);
        send_word(ADC_TOP, 1'b1);

        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin send_idle_pct = 28; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            phase_base = int'($urandom_range(ADC_TOP, 0));
            if (phase == 3)
                apply_config('1, clamp_sample(phase_base), {$urandom, $urandom}, '1);
            else
                apply_config(LIMIT_W'($urandom_range(12, 0)),
                             clamp_sample(phase_base + int'($urandom_range(40, 0)) - 20),
                             {$urandom, $urandom}, SHIFT_W'($urandom_range(15, 0)));
            if (phase == 2) stall_req = 1'b1;
            // new config seen mid-waveform, before the next start
            for (k = 0; k < 3; k++) send_word(clamp_sample(phase_base), 1'b0);
            while (words_sent < 25 + 250 * (phase + 1)) begin
                if ($urandom_range(9, 0) == 0) begin
                    send_word(SAMPLE_BITS'($urandom_range(ADC_TOP, 0)),
                              1'($urandom_range(1, 0)));
                end else begin
                    case ($urandom_range(9, 0))
                        0: base = 0;
                        1: base = ADC_TOP;
                        2, 3: base = int'($urandom_range(ADC_TOP, 0));
                        default: base = phase_base + int'($urandom_range(200, 0)) - 100;
                    endcase
                    send_waveform(base);
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
